// File: rtl/core/vlbc_pkg.sv
// ----------------------------------------------------------------------------
// vlbc_pkg: shared types and constants of the vertical line buffer filter
// Tap count, line memory geometry, register map, pipeline control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package vlbc_pkg;

  localparam int TAPS      = 3;
  localparam int MAX_WIDTH = 1024;
  localparam int LINES     = TAPS - 1;
  localparam int NUM_COEFF = 5;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int EW_W   = COL_W + 1;
  localparam int FW_W   = 11;
  localparam int FH_W   = 16;
  localparam int FHX_W  = FH_W + 1;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;
  localparam int IDX_W  = 3;

  // register indexes (byte address / 4)
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_COEFF_0      = 3'd2;
  localparam logic [IDX_W-1:0] REG_COEFF_1      = 3'd3;
  localparam logic [IDX_W-1:0] REG_COEFF_2      = 3'd4;
  localparam logic [IDX_W-1:0] REG_COEFF_3      = 3'd5;
  localparam logic [IDX_W-1:0] REG_COEFF_4      = 3'd6;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef word_t [TAPS-1:0]         tap_vec_t;
  typedef word_t [LINES-1:0]        line_vec_t;
  typedef logic [COL_W-1:0]         col_t;

  // per-stage load enables, one per pipeline register rank
  typedef struct packed {
    logic load_s1;
    logic load_s2;
    logic load_s3;
    logic load_out;
  } pipe_ctrl_t;

  // width in use: zero acts as one, clamp to the line memory depth
  function automatic logic [EW_W-1:0] eff_width(input logic [FW_W-1:0] fw);
    logic [EW_W-1:0] r;
    if (fw == '0) begin
      r = EW_W'(1);
    end else if (32'(fw) > 32'(MAX_WIDTH)) begin
      r = EW_W'(MAX_WIDTH);
    end else begin
      r = EW_W'(fw);
    end
    return r;
  endfunction

  function automatic logic [FHX_W-1:0] eff_height(input logic [FH_W-1:0] fh);
    logic [FHX_W-1:0] r;
    if (fh == '0) begin
      r = FHX_W'(1);
    end else begin
      r = FHX_W'(fh);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/vertical_line_buffer_convolution.sv
// ----------------------------------------------------------------------------
// vertical_line_buffer_convolution: vertical FIR over a raster pixel stream
// Line memories hold the older rows; each pixel gives the weighted column sum.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_pixel_in) takes one signed 32-bit
//   pixel per beat in raster order. Output channel (out_valid / out_stall /
//   out_conv_out) gives one wrapped 32-bit sum per pixel from row TAPS-1 of
//   each frame onward; pixels of the first rows update the line memories and
//   give no beat.
//   Throughput: one pixel per cycle while out_stall stays low. The pixel
//   passes four register ranks (memory read, window, products, sum), the
//   first of them loaded at the accepting edge.
//   Stall: the stages hold and fill bubbles toward the output; in_stall
//   rises only once every stage up to the output register holds a beat.
//   Same-column back-to-back pixels (width one) get the write of the pixel
//   ahead by forwarding, so such pixels cause no stall.
//   Reset (rst_n low, synchronous) empties the pipeline, zeros the row and
//   column counters, restores width and height to 1024 and the weights to
//   zero. The line memories are not cleared; the first rows of a frame fill
//   them before any result reads them.
//   APB port: write registers only while the pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module vertical_line_buffer_convolution (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // pixel input
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [31:0]           in_pixel_in,
  // result output
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [31:0]                out_conv_out,
  // register port
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [vlbc_pkg::ADDR_W-1:0]  cfg_paddr,
  input  wire logic [vlbc_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [vlbc_pkg::DATA_W-1:0]       cfg_prdata,
  output logic                              cfg_pready
);

  // configuration registers
  logic [vlbc_pkg::FW_W-1:0]                 frame_width_r;
  logic [vlbc_pkg::FH_W-1:0]                 frame_height_r;
  vlbc_pkg::word_t [vlbc_pkg::NUM_COEFF-1:0] coeff_r;
  vlbc_pkg::tap_vec_t                        coeff_taps;

  logic [vlbc_pkg::IDX_W-1:0] reg_idx;
  logic                       reg_wr;

  // raster counters
  vlbc_pkg::col_t            column_count_r;
  vlbc_pkg::col_t            column_count_nxt;
  logic [vlbc_pkg::FH_W-1:0] row_count_r;
  logic [vlbc_pkg::FH_W-1:0] row_count_nxt;
  logic [vlbc_pkg::EW_W-1:0] col_plus;
  logic [vlbc_pkg::FHX_W-1:0] row_plus;
  logic                      produce;

  // pipeline occupancy; prod bits mark beats that reach the output
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic p1_r, p2_r, p3_r;
  logic en1, en2, en3, en_out;
  logic accept;
  vlbc_pkg::pipe_ctrl_t ctrl;

  vlbc_pkg::tap_vec_t win2;
  vlbc_pkg::word_t    sum;

  // --------------------------------------------------------------------------
  // Register port: writes in the access phase, reads are combinational
  // --------------------------------------------------------------------------
  assign reg_idx    = cfg_paddr[vlbc_pkg::ADDR_W-1:2];
  assign reg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= vlbc_pkg::FW_W'(1024);
      frame_height_r <= vlbc_pkg::FH_W'(1024);
      coeff_r        <= '0;
    end else if (reg_wr) begin
      case (reg_idx)
        vlbc_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_pwdata[vlbc_pkg::FW_W-1:0];
        vlbc_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_pwdata[vlbc_pkg::FH_W-1:0];
        vlbc_pkg::REG_COEFF_0:      coeff_r[0]     <= cfg_pwdata;
        vlbc_pkg::REG_COEFF_1:      coeff_r[1]     <= cfg_pwdata;
        vlbc_pkg::REG_COEFF_2:      coeff_r[2]     <= cfg_pwdata;
        vlbc_pkg::REG_COEFF_3:      coeff_r[3]     <= cfg_pwdata;
        vlbc_pkg::REG_COEFF_4:      coeff_r[4]     <= cfg_pwdata;
        default: ; // drop writes past the map
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      vlbc_pkg::REG_FRAME_WIDTH:  cfg_prdata = vlbc_pkg::DATA_W'(frame_width_r);
      vlbc_pkg::REG_FRAME_HEIGHT: cfg_prdata = vlbc_pkg::DATA_W'(frame_height_r);
      vlbc_pkg::REG_COEFF_0:      cfg_prdata = coeff_r[0];
      vlbc_pkg::REG_COEFF_1:      cfg_prdata = coeff_r[1];
      vlbc_pkg::REG_COEFF_2:      cfg_prdata = coeff_r[2];
      vlbc_pkg::REG_COEFF_3:      cfg_prdata = coeff_r[3];
      vlbc_pkg::REG_COEFF_4:      cfg_prdata = coeff_r[4];
      default:                    cfg_prdata = '0;
    endcase
  end

  // only the first TAPS weights take part
  always_comb begin
    for (int i = 0; i < vlbc_pkg::TAPS; i++) begin
      coeff_taps[i] = coeff_r[i];
    end
  end

  // --------------------------------------------------------------------------
  // Stage control: each rank loads when empty or when the next rank moves
  // --------------------------------------------------------------------------
  assign en_out   = ~out_valid_r | ~out_stall;
  assign en3      = ~v3_r | en_out;
  assign en2      = ~v2_r | en3;
  assign en1      = ~v1_r | en2;
  assign in_stall = ~en1;
  assign accept   = in_valid & en1;

  assign ctrl.load_s1  = en1;
  assign ctrl.load_s2  = en2;
  assign ctrl.load_s3  = en3;
  assign ctrl.load_out = en_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
      p1_r        <= 1'b0;
      p2_r        <= 1'b0;
      p3_r        <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= accept;
        p1_r <= produce;
      end
      if (en2) begin
        v2_r <= v1_r;
        p2_r <= p1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
        p3_r <= p2_r;
      end
      if (en_out) begin
        // drop beats of the first rows of a frame here
        out_valid_r <= v3_r & p3_r;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Raster counters: advance on each accepted pixel, wrap against the
  // current width and height
  // --------------------------------------------------------------------------
  assign produce  = row_count_r >= vlbc_pkg::FH_W'(vlbc_pkg::TAPS - 1);
  assign col_plus = vlbc_pkg::EW_W'(column_count_r) + vlbc_pkg::EW_W'(1);
  assign row_plus = vlbc_pkg::FHX_W'(row_count_r) + vlbc_pkg::FHX_W'(1);

  always_comb begin
    column_count_nxt = column_count_r;
    row_count_nxt    = row_count_r;
    if (col_plus >= vlbc_pkg::eff_width(frame_width_r)) begin
      column_count_nxt = '0;
      if (row_plus >= vlbc_pkg::eff_height(frame_height_r)) begin
        row_count_nxt = '0;
      end else begin
        row_count_nxt = row_plus[vlbc_pkg::FH_W-1:0];
      end
    end else begin
      column_count_nxt = col_plus[vlbc_pkg::COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= '0;
      row_count_r    <= '0;
    end else if (accept) begin
      column_count_r <= column_count_nxt;
      row_count_r    <= row_count_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  vlbc_window u_window (
    .clk      (clk),
    .ctrl     (ctrl),
    .s1_valid (v1_r),
    .col_in   (column_count_r),
    .pix_in   (in_pixel_in),
    .win_out  (win2)
  );

  vlbc_mac u_mac (
    .clk      (clk),
    .ctrl     (ctrl),
    .win_in   (win2),
    .coeff_in (coeff_taps),
    .sum_out  (sum)
  );

  assign out_valid    = out_valid_r;
  assign out_conv_out = sum;

endmodule

`default_nettype wire

// File: rtl/core/vlbc_window.sv
// ----------------------------------------------------------------------------
// vlbc_window: line memories and vertical window assembly
// Reads the column at accept, forwards the write of the item ahead when it
// hits the same column, writes the shifted column back, registers the window.
// ----------------------------------------------------------------------------
`default_nettype none

module vlbc_window (
  input  wire logic                 clk,
  input  wire vlbc_pkg::pipe_ctrl_t ctrl,
  input  wire logic                 s1_valid,
  input  wire vlbc_pkg::col_t       col_in,
  input  wire vlbc_pkg::word_t      pix_in,
  output vlbc_pkg::tap_vec_t        win_out
);

  vlbc_pkg::word_t    line_mem [vlbc_pkg::LINES][vlbc_pkg::MAX_WIDTH];

  vlbc_pkg::line_vec_t rd1_r;
  vlbc_pkg::line_vec_t byp1_r;
  logic                fwd1_r;
  vlbc_pkg::col_t      col1_r;
  vlbc_pkg::word_t     pix1_r;
  vlbc_pkg::tap_vec_t  win2_r;

  vlbc_pkg::tap_vec_t  win1;
  vlbc_pkg::line_vec_t wr_data;
  logic                wr_en;

  // window of the item in stage one, oldest row first
  always_comb begin
    for (int i = 0; i < vlbc_pkg::LINES; i++) begin
      win1[i] = fwd1_r ? byp1_r[i] : rd1_r[i];
    end
    win1[vlbc_pkg::TAPS-1] = pix1_r;
    for (int i = 0; i < vlbc_pkg::LINES; i++) begin
      wr_data[i] = win1[i+1];
    end
  end

  // write back exactly once, as the item leaves stage one
  assign wr_en = s1_valid & ctrl.load_s2;

  always_ff @(posedge clk) begin
    for (int l = 0; l < vlbc_pkg::LINES; l++) begin
      if (wr_en) begin
        line_mem[l][col1_r] <= wr_data[l];
      end
      if (ctrl.load_s1) begin
        rd1_r[l] <= line_mem[l][col_in];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_s1) begin
      col1_r <= col_in;
      pix1_r <= pix_in;
      // same-edge write to the column being read: take the new values
      fwd1_r <= wr_en & (col1_r == col_in);
      byp1_r <= wr_data;
    end
    if (ctrl.load_s2) begin
      win2_r <= win1;
    end
  end

  assign win_out = win2_r;

endmodule

`default_nettype wire

// File: rtl/core/vlbc_mac.sv
// ----------------------------------------------------------------------------
// vlbc_mac: tap multipliers and sum
// One registered rank of 32x32 products (low word), then the wrapped sum.
// ----------------------------------------------------------------------------
`default_nettype none

module vlbc_mac (
  input  wire logic                 clk,
  input  wire vlbc_pkg::pipe_ctrl_t ctrl,
  input  wire vlbc_pkg::tap_vec_t   win_in,
  input  wire vlbc_pkg::tap_vec_t   coeff_in,
  output vlbc_pkg::word_t           sum_out
);

  vlbc_pkg::tap_vec_t prod3_r;
  vlbc_pkg::word_t    sum_r;
  vlbc_pkg::word_t    sum_nxt;

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < vlbc_pkg::TAPS; i++) begin
      sum_nxt = vlbc_pkg::word_t'(sum_nxt + prod3_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_s3) begin
      for (int i = 0; i < vlbc_pkg::TAPS; i++) begin
        prod3_r[i] <= vlbc_pkg::word_t'(win_in[i] * coeff_in[i]);
      end
    end
    if (ctrl.load_out) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum_out = sum_r;

endmodule

`default_nettype wire

// File: tb/sv/tb_vertical_line_buffer_convolution.sv
// ----------------------------------------------------------------------------
// tb_vertical_line_buffer_convolution: self-checking bench for the vertical FIR
// Streams raster pixels through the valid/stall input and keeps a local copy
// of the line memories, row/column counters and tap weights. Every output beat
// is compared in order against the column sum computed here. APB writes
// reshape the frame and weights between phases, under several idle/stall mixes.
// ----------------------------------------------------------------------------

module tb_vertical_line_buffer_convolution;
  import vlbc_pkg::*;

  // index with no register behind it; writes there must change nothing
  localparam logic [IDX_W-1:0] REG_UNMAPPED = 3'd7;
  // pipeline depth is four ranks; leave margin for beats that give no result
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_BEATS = 12;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  word_t             in_pixel_in;
  logic              out_valid;
  logic              out_stall = 1'b0;
  word_t             out_conv_out;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  vertical_line_buffer_convolution dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pixel_in  (in_pixel_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_conv_out (out_conv_out),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready)
  );

  // --------------------------------------------------------------------------
  // Local copy of the filter state. line_known tracks which line entries hold
  // a real pixel, so width changes never expose never-written memory.
  // --------------------------------------------------------------------------
  word_t           line_mem   [LINES][MAX_WIDTH];
  bit              line_known [LINES][MAX_WIDTH];
  int unsigned     row_cnt;
  int unsigned     col_cnt;
  logic [FW_W-1:0] frame_width_reg;
  logic [FH_W-1:0] frame_height_reg;
  word_t           coeff_reg [NUM_COEFF];
  word_t           conv_expected [$];

  int unsigned     send_idle_pct;
  int unsigned     recv_stall_pct;
  int              error_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #5_000_000;
    $display("[vertical_line_buffer_convolution] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Frame geometry as the block uses it: zero acts as one, width clamps to
  // the line memory depth.
  // --------------------------------------------------------------------------
  function automatic int unsigned width_in_use(input logic [FW_W-1:0] fw);
    if (fw == '0) return 1;
    if (fw > MAX_WIDTH) return MAX_WIDTH;
    return fw;
  endfunction

  function automatic int unsigned height_in_use(input logic [FH_W-1:0] fh);
    return (fh == '0) ? 1 : fh;
  endfunction

  // Column sum for one accepted pixel, then shift the column up one row and
  // advance the counters against the bounds in force right now.
  function automatic void predict_pixel(input word_t px);
    int unsigned       col;
    logic [DATA_W-1:0] acc;
    word_t             win [TAPS];
    col = (col_cnt >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_cnt;
    for (int i = 0; i < LINES; i++) win[i] = line_mem[i][col];
    win[TAPS-1] = px;
    acc = '0;
    for (int i = 0; i < TAPS; i++) acc = acc + DATA_W'(win[i] * coeff_reg[i]);
    for (int i = 0; i < LINES; i++) begin
      line_mem[i][col]   = win[i+1];
      line_known[i][col] = (i == LINES - 1) ? 1'b1 : line_known[i+1][col];
    end
    if (row_cnt >= TAPS - 1) conv_expected.push_back(acc);
    col_cnt++;
    if (col_cnt >= width_in_use(frame_width_reg)) begin
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= height_in_use(frame_height_reg)) row_cnt = 0;
    end
  endfunction

  // Pick a width that cannot make a later result read an unwritten entry.
  // At a frame start anything goes: the first rows refill every column in
  // use. Mid-frame, stay inside the prefix of columns whose lines are all
  // written; if there is none, keep the width already in force.
  function automatic logic [FW_W-1:0] safe_width(input logic [FW_W-1:0] want);
    int unsigned filled;
    filled = 0;
    if (row_cnt == 0 && col_cnt == 0) return want;
    while (filled < MAX_WIDTH && line_known[0][filled]) filled++;
    if (width_in_use(want) <= filled) return want;
    if (filled == 0) return frame_width_reg;
    return FW_W'(filled);
  endfunction

  function automatic word_t extreme_word();
    case ($urandom_range(4))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0001;
      default: return 32'h0000_0000;
    endcase
  endfunction

  function automatic word_t random_pixel();
    if ($urandom_range(9) == 0) return extreme_word();
    return word_t'($urandom);
  endfunction

  // Weights: small signed values, so sums stay readable, mixed with corners
  // and full-range values that wrap hard.
  function automatic word_t random_coeff();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 20) return extreme_word();
    if (pick < 60) return word_t'($signed($urandom_range(16)) - 8);
    return word_t'($urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Result checker and receiver stall. Compare each accepted beat with the
  // oldest expectation, then draw the stall for the next cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (conv_expected.size() == 0) begin
        $display("%0t: unexpected conv_out beat, expected none, actual 0x%08h",
                 $time, out_conv_out);
        error_count++;
      end else begin
        if (out_conv_out !== conv_expected[0]) begin
          $display("%0t: conv_out mismatch, expected 0x%08h (%0d), actual 0x%08h (%0d)",
                   $time, conv_expected[0], conv_expected[0], out_conv_out, out_conv_out);
          error_count++;
        end
        void'(conv_expected.pop_front());
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------

  // Send one pixel beat: optional idle cycles with scrambled payload, then
  // hold valid and data until the block takes the beat.
  task automatic send_pixel(input word_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid    <= 1'b0;
      in_pixel_in <= word_t'($urandom);
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_pixel_in <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pixel(px);
  endtask

  // APB write: setup cycle, access cycle, then drop select for one cycle so
  // back-to-back writes never lower and raise psel in the same step.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH:  frame_width_reg  = val[FW_W-1:0];
      REG_FRAME_HEIGHT: frame_height_reg = val[FH_W-1:0];
      REG_COEFF_0, REG_COEFF_1, REG_COEFF_2, REG_COEFF_3, REG_COEFF_4:
        coeff_reg[idx - REG_COEFF_0] = val;
      default: ;
    endcase
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_width(input logic [FW_W-1:0] want);
    write_reg(REG_FRAME_WIDTH, DATA_W'(safe_width(want)));
  endtask

  task automatic set_coeffs(input word_t c0, input word_t c1, input word_t c2,
                            input word_t c3, input word_t c4);
    write_reg(REG_COEFF_0, c0);
    write_reg(REG_COEFF_1, c1);
    write_reg(REG_COEFF_2, c2);
    write_reg(REG_COEFF_3, c3);
    write_reg(REG_COEFF_4, c4);
  endtask

  // Drain: stop sending, wait for every expected beat, then let pixels that
  // give no result clear the pipeline before any register changes.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (conv_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Feed random pixels until the counters sit at the top of a frame.
  task automatic run_to_frame_start();
    while (!(row_cnt == 0 && col_cnt == 0)) send_pixel(random_pixel());
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Width one: every pixel hits the same column back to back, so the block
  // must forward the write of the pixel ahead. Corner pixels against corner
  // weights; the fourth and fifth weights are set but lie beyond the taps.
  // Height five runs the frame wrap; the first rows then give no beat again.
  task automatic test_single_column();
    word_t pix [10];
    pix = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0000_0000,
            32'h0000_0001, 32'h8000_0000, 32'h7fff_ffff, 32'h5555_5555,
            32'haaaa_aaaa, 32'hffff_fffe};
    wait_idle();
    set_idling(0, 0);
    set_width(11'd1);
    write_reg(REG_FRAME_HEIGHT, 32'd5);
    set_coeffs(32'h0000_0001, 32'hffff_ffff, 32'h7fff_ffff, 32'h1234_5678,
               32'h8000_0000);
    foreach (pix[i]) send_pixel(pix[i]);
  endtask

  // Zero width and zero height act as one; a height of TAPS-1 is a frame too
  // short to ever give a result. No beat may come out here.
  task automatic test_short_frames();
    wait_idle();
    set_width(11'd0);
    write_reg(REG_FRAME_HEIGHT, 32'd0);
    repeat (3) send_pixel(random_pixel());
    wait_idle();
    set_width(11'd3);
    write_reg(REG_FRAME_HEIGHT, DATA_W'(TAPS - 1));
    repeat (3) send_pixel(random_pixel());
  endtask

  // A write past the last register must be dropped: weights stay as they are.
  task automatic test_unmapped_register();
    wait_idle();
    write_reg(REG_FRAME_HEIGHT, 32'd6);
    write_reg(REG_UNMAPPED, $urandom);
    repeat (3) send_pixel(random_pixel());
  endtask

  // Shrink the width while the column counter lies past the new bound, so
  // the column wraps at the next pixel; height ends at TAPS+2, above the row.
  task automatic test_midframe_bounds();
    wait_idle();
    run_to_frame_start();
    wait_idle();
    set_width(11'd4);
    set_coeffs(random_coeff(), random_coeff(), random_coeff(), random_coeff(),
               random_coeff());
    repeat (4 * 3 + 3) send_pixel(random_pixel());
    wait_idle();
    set_width(11'd2);
    write_reg(REG_FRAME_HEIGHT, 32'd2);
    write_reg(REG_FRAME_HEIGHT, 32'd2 + DATA_W'(TAPS));
    repeat (6) send_pixel(random_pixel());
  endtask

  // Random frames under four traffic mixes. Registers change between phases
  // wherever the counters happen to be, so mid-frame changes come for free.
  task automatic test_random_traffic();
    int unsigned send_mix  [4];
    int unsigned stall_mix [4];
    int unsigned pick;
    logic [FW_W-1:0] w;
    logic [FH_W-1:0] h;
    send_mix  = '{0, 69, 0, 7};
    stall_mix = '{0, 0, 69, 7};
    for (int m = 0; m < 4; m++) begin
      for (int ph = 0; ph < 4; ph++) begin
        wait_idle();
        set_idling(send_mix[m], stall_mix[m]);
        pick = $urandom_range(99);
        if (pick < 4)       w = '0;
        else if (pick < 7)  w = FW_W'($urandom_range(1025, 2047));
        else if (pick < 12) w = FW_W'(1);
        else if (pick < 20) w = FW_W'($urandom_range(17, 64));
        else                w = FW_W'($urandom_range(2, 16));
        pick = $urandom_range(99);
        if (pick < 3)       h = '1;
        else if (pick < 10) h = FH_W'($urandom_range(TAPS - 1));
        else                h = FH_W'($urandom_range(TAPS, 8));
        set_width(w);
        write_reg(REG_FRAME_HEIGHT, DATA_W'(h));
        set_coeffs(random_coeff(), random_coeff(), random_coeff(), random_coeff(),
                   random_coeff());
        repeat (RANDOM_BEATS) send_pixel(random_pixel());
      end
    end
  endtask

  // A width above the line depth clamps to it: one row at that width ends
  // after MAX_WIDTH pixels, and its column counter runs through every address
  // of the line memories. A narrow width afterwards shows where the row ended:
  // only if it ended at the clamp do the following rows give their results.
  task automatic test_full_width();
    wait_idle();
    set_idling(0, 0);
    set_width(11'd4);
    write_reg(REG_FRAME_HEIGHT, DATA_W'(TAPS));
    run_to_frame_start();
    wait_idle();
    set_width(11'd4);
    set_coeffs(random_coeff(), random_coeff(), random_coeff(), random_coeff(),
               random_coeff());
    repeat (4 * TAPS) send_pixel(random_pixel());
    wait_idle();
    set_width(11'h7ff);
    repeat (MAX_WIDTH) send_pixel(random_pixel());
    wait_idle();
    set_width(11'd4);
    repeat (4 * (TAPS - 1)) send_pixel(random_pixel());
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: hold reset, run the tests, drain, report.
  // --------------------------------------------------------------------------
  initial begin
    in_valid    <= 1'b0;
    in_pixel_in <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    rst_n       <= 1'b0;
    // register and counter values the block comes out of reset with
    frame_width_reg  = FW_W'(1024);
    frame_height_reg = FH_W'(1024);
    foreach (coeff_reg[i]) coeff_reg[i] = '0;
    row_cnt        = 0;
    col_cnt        = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    error_count    = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_column();
    test_short_frames();
    test_unmapped_register();
    test_midframe_bounds();
    test_random_traffic();
    test_full_width();

    wait_idle();
    if (error_count == 0) begin
      $display("[vertical_line_buffer_convolution] OK");
    end else begin
      $display("[vertical_line_buffer_convolution] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/vlbc_pkg.sv
rtl/core/vlbc_window.sv
rtl/core/vlbc_mac.sv
rtl/core/vertical_line_buffer_convolution.sv
tb/sv/tb_vertical_line_buffer_convolution.sv
